// ===== sv/pec_pkg.sv =====
package pec_pkg;

  localparam int ERR_WIDTH_DEF = 16;
  localparam int SUM_WIDTH_DEF = 32;
  localparam int GAIN_W        = 16;
  localparam int LIMIT_W       = 31;
  localparam int OUT_W         = 35;
  localparam int CFG_ADDR_W    = 2;
  localparam int CFG_DATA_W    = 31;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_I = 2'd1,
    REG_GAIN_D = 2'd2,
    REG_LIMIT  = 2'd3
  } cfg_reg_t;

endpackage

// ===== sv/pec_err_if.sv =====
interface pec_err_if #(
  parameter int W = pec_pkg::ERR_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] error_in;

  modport source (output valid, output error_in, input ready);
  modport sink   (input valid, input error_in, output ready);
endinterface

// ===== sv/pec_drive_if.sv =====
interface pec_drive_if;
  import pec_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] drive_out;

  modport source (output valid, output drive_out, input ready);
  modport sink   (input valid, input drive_out, output ready);
endinterface

// ===== sv/pec_accum.sv =====
module pec_accum #(
  parameter int ERR_WIDTH = pec_pkg::ERR_WIDTH_DEF,
  parameter int SUM_WIDTH = pec_pkg::SUM_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  logic signed [ERR_WIDTH-1:0] err,
  output logic signed [SUM_WIDTH-1:0] sum_q_r,
  output logic signed [ERR_WIDTH-1:0] err_q_r,
  output logic signed [ERR_WIDTH:0]   ed_q_r
);
  import pec_pkg::*;

  localparam int SW1 = ((SUM_WIDTH > ERR_WIDTH) ? SUM_WIDTH : ERR_WIDTH) + 1;
  localparam logic signed [SW1-1:0] SUM_MAX =
    {{(SW1-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SW1-1:0] SUM_MIN = ~SUM_MAX;

  logic signed [SUM_WIDTH-1:0] error_sum_r, error_sum_nxt;
  logic signed [ERR_WIDTH-1:0] last_error_r;
  logic signed [SW1-1:0]       raw_sum;
  logic signed [ERR_WIDTH:0]   ed;
  logic                        gate;

  always_comb begin
    raw_sum = SW1'(error_sum_r) + SW1'(err);
    if (raw_sum > SUM_MAX) begin
      error_sum_nxt = SUM_MAX[SUM_WIDTH-1:0];
    end else if (raw_sum < SUM_MIN) begin
      error_sum_nxt = SUM_MIN[SUM_WIDTH-1:0];
    end else begin
      error_sum_nxt = raw_sum[SUM_WIDTH-1:0];
    end
  end

  // D only when error and its change share a nonzero sign
  always_comb begin
    ed   = (ERR_WIDTH+1)'(err) - (ERR_WIDTH+1)'(last_error_r);
    gate = (!err[ERR_WIDTH-1] && (err != '0) && !ed[ERR_WIDTH] && (ed != '0)) ||
           (err[ERR_WIDTH-1] && ed[ERR_WIDTH]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else if (take) begin
      error_sum_r  <= error_sum_nxt;
      last_error_r <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sum_q_r <= error_sum_nxt;
      err_q_r <= err;
      ed_q_r  <= gate ? ed : '0;
    end
  end

endmodule

// ===== sv/pid_error_controller.sv =====
// PID step on a stream of signed Q8.8 error samples, one Q19.16 drive value per
// sample. Three pipeline stages (sum update and derivative gating, the three
// gain multiplies, integral clamp and final add) register each result in turn,
// with one request accepted every cycle while the output is not stalled;
// each stage holds its own item and only stalls when the stage after it is
// full, so a waiting result does not block intake until the pipe fills. The
// running error sum saturates, the integral term is clamped to the limit
// register, the final sum is not saturated. Write configuration only while
// the pipe is empty.
module pid_error_controller #(
  parameter int ERR_WIDTH = pec_pkg::ERR_WIDTH_DEF,
  parameter int SUM_WIDTH = pec_pkg::SUM_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  pec_err_if.sink                            in_chan,
  pec_drive_if.source                        out_chan,
  input  logic                               cfg_we,
  input  logic [pec_pkg::CFG_ADDR_W-1:0]     cfg_index,
  input  logic [pec_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pec_pkg::*;

  localparam int PW  = GAIN_W + ERR_WIDTH;
  localparam int IW  = GAIN_W + SUM_WIDTH;
  localparam int DW  = GAIN_W + ERR_WIDTH + 1;
  localparam int ICW = LIMIT_W + 1;
  localparam int TW  = ((ERR_WIDTH + 19) > OUT_W) ? (ERR_WIDTH + 19) : OUT_W;

  logic signed [GAIN_W-1:0]  gain_p_r, gain_i_r, gain_d_r;
  logic        [LIMIT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      limit_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAIN_P: gain_p_r <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I: gain_i_r <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D: gain_d_r <= cfg_data[GAIN_W-1:0];
        REG_LIMIT:  limit_r  <= cfg_data[LIMIT_W-1:0];
        default:    ;
      endcase
    end
  end

  // pipeline flow control
  logic v1_r, v2_r, v3_r;
  logic ready1, ready2, ready3;
  logic take;

  assign ready3        = !v3_r || out_chan.ready;
  assign ready2        = !v2_r || ready3;
  assign ready1        = !v1_r || ready2;
  assign in_chan.ready = ready1;
  assign take          = in_chan.valid && ready1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= in_chan.valid;
      if (ready2) v2_r <= v1_r;
      if (ready3) v3_r <= v2_r;
    end
  end

  // stage 1: state update
  logic signed [SUM_WIDTH-1:0] sum_q_r;
  logic signed [ERR_WIDTH-1:0] err_q_r;
  logic signed [ERR_WIDTH:0]   ed_q_r;

  pec_accum #(
    .ERR_WIDTH (ERR_WIDTH),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .err     (in_chan.error_in),
    .sum_q_r (sum_q_r),
    .err_q_r (err_q_r),
    .ed_q_r  (ed_q_r)
  );

  // stage 2: products
  logic signed [PW-1:0] prod_p_r;
  logic signed [IW-1:0] prod_i_r;
  logic signed [DW-1:0] prod_d_r;

  always_ff @(posedge clk) begin
    if (v1_r && ready2) begin
      prod_p_r <= PW'(gain_p_r) * PW'(err_q_r);
      prod_i_r <= IW'(gain_i_r) * IW'(sum_q_r);
      prod_d_r <= DW'(gain_d_r) * DW'(ed_q_r);
    end
  end

  // stage 3: clamp I, add terms
  logic signed [IW-1:0]  lim_pos, lim_neg, i_clamp;
  logic signed [ICW-1:0] i_term;
  logic signed [TW-1:0]  total;
  logic signed [OUT_W-1:0] drive_r;

  always_comb begin
    lim_pos = IW'(limit_r);
    lim_neg = -lim_pos;
    if (prod_i_r > lim_pos) begin
      i_clamp = lim_pos;
    end else if (prod_i_r < lim_neg) begin
      i_clamp = lim_neg;
    end else begin
      i_clamp = prod_i_r;
    end
    i_term = i_clamp[ICW-1:0];
    total  = TW'(prod_p_r) + TW'(i_term) + TW'(prod_d_r);
  end

  always_ff @(posedge clk) begin
    if (v2_r && ready3) begin
      drive_r <= total[OUT_W-1:0];
    end
  end

  assign out_chan.valid     = v3_r;
  assign out_chan.drive_out = drive_r;

  // checks
  a_take_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> v1_r)
    else $error("accepted request did not reach stage 1");

  a_empty_s1_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_chan.ready)
    else $error("intake stalled with empty stage 1");

  a_d_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && ready2 && (ed_q_r == '0)) |=> (prod_d_r == '0))
    else $error("derivative term not zero when gated off");

  a_i_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> ((i_clamp <= lim_pos) && (i_clamp >= lim_neg)))
    else $error("integral term outside limit");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !out_chan.ready) |=> (v3_r && $stable(drive_r)))
    else $error("stalled result changed");

endmodule
